### hw/rtl/ptok_pkg.sv
// Package for the parallel automata tokenizer: matcher state codes, token kinds,
// keyword and operator tables, and the matcher step struct. No dependencies.
`timescale 1ns / 1ps
package ptok_pkg;

    localparam int MAX_TOKEN_LEN = 32;
    localparam int NUM_M         = 15;
    localparam int NUM_KW        = 6;
    localparam int NUM_OP        = 6;

    typedef logic [1:0] t_mst;
    localparam t_mst ST_RUN = 2'd0;
    localparam t_mst ST_ACC = 2'd1;
    localparam t_mst ST_REJ = 2'd2;

    typedef logic [3:0] t_kind;
    localparam t_kind K_ERROR    = 4'd0;
    localparam t_kind K_NUMBER   = 4'd1;
    localparam t_kind K_FIRST_OP = 4'd2;
    localparam t_kind K_IDENT    = 4'd8;
    localparam t_kind K_FIRST_KW = 4'd9;
    localparam t_kind K_EOF      = 4'd15;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;

    typedef t_mst [NUM_M-1:0]        t_mst_vec;
    typedef logic [NUM_KW-1:0][2:0]  t_kidx_vec;

    typedef struct packed {
        t_mst_vec  st_nx;
        t_kidx_vec kidx_nx;
        logic      running;   // some matcher still running after this char
        logic      any_acc;
        t_kind     acc_kind;  // latest accepting matcher after this char
        t_kind     cut_kind;  // winner judged from states before this char
    } t_step;

    // Keyword spelling, char k in bits [8k+7:8k].
    function automatic logic [63:0] kw_word(input logic [2:0] kw);
        logic [63:0] w;
        case (kw)
            3'd0:    w = {32'h0, "clac"};
            3'd1:    w = {48'h0, "dc"};
            3'd2:    w = {48'h0, "fi"};
            3'd3:    w = {40'h0, "rof"};
            3'd4:    w = {40'h0, "rav"};
            3'd5:    w = {24'h0, "elihw"};
            default: w = 64'h0;
        endcase
        return w;
    endfunction

    function automatic logic [2:0] kw_len(input logic [2:0] kw);
        logic [2:0] l;
        case (kw)
            3'd0:    l = 3'd4;
            3'd1:    l = 3'd2;
            3'd2:    l = 3'd2;
            3'd3:    l = 3'd3;
            3'd4:    l = 3'd3;
            3'd5:    l = 3'd5;
            default: l = 3'd1;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] op_char(input logic [2:0] op);
        logic [7:0] c;
        case (op)
            3'd0:    c = "+";
            3'd1:    c = "-";
            3'd2:    c = "*";
            3'd3:    c = "/";
            3'd4:    c = "(";
            3'd5:    c = ")";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/ptok_match.sv
// Matcher bank step: advances all fifteen matchers by one character.
// Depends on ptok_pkg.
`timescale 1ns / 1ps
module ptok_match (
    input  logic [7:0]           i_ch,
    input  logic                 i_fill_zero,
    input  ptok_pkg::t_mst_vec   i_st,
    input  ptok_pkg::t_kidx_vec  i_kidx,
    output ptok_pkg::t_step      o_step
);

    logic is_dig, is_alp, is_blank;

    always_comb begin
        logic [2:0]  k;
        logic [2:0]  kn;
        logic [2:0]  kl;
        logic [63:0] kw;
        is_dig   = (i_ch >= "0") && (i_ch <= "9");
        is_alp   = ((i_ch >= "a") && (i_ch <= "z")) || ((i_ch >= "A") && (i_ch <= "Z"));
        is_blank = (i_ch == ptok_pkg::CH_SPACE) || (i_ch == ptok_pkg::CH_NL);

        o_step.st_nx   = i_st;
        o_step.kidx_nx = i_kidx;

        o_step.st_nx[0] = (i_fill_zero && is_blank) ? ptok_pkg::ST_REJ : ptok_pkg::ST_ACC;

        if (i_st[1] == ptok_pkg::ST_RUN) begin
            if (is_dig)
                o_step.st_nx[1] = ptok_pkg::ST_RUN;
            else
                o_step.st_nx[1] = i_fill_zero ? ptok_pkg::ST_REJ : ptok_pkg::ST_ACC;
        end

        for (int i = 0; i < ptok_pkg::NUM_OP; i++) begin
            o_step.st_nx[2+i] = (i_st[2+i] == ptok_pkg::ST_RUN
                                 && i_ch == ptok_pkg::op_char(3'(i)))
                                ? ptok_pkg::ST_ACC : ptok_pkg::ST_REJ;
        end

        if (i_st[8] == ptok_pkg::ST_RUN) begin
            if (i_fill_zero)
                o_step.st_nx[8] = is_alp ? ptok_pkg::ST_RUN : ptok_pkg::ST_REJ;
            else
                o_step.st_nx[8] = (is_alp || is_dig) ? ptok_pkg::ST_RUN : ptok_pkg::ST_ACC;
        end

        for (int i = 0; i < ptok_pkg::NUM_KW; i++) begin
            k  = i_kidx[i];
            kl = ptok_pkg::kw_len(3'(i));
            kw = ptok_pkg::kw_word(3'(i));
            kn = k + 3'd1;
            if (i_st[9+i] != ptok_pkg::ST_ACC) begin
                if (i_st[9+i] == ptok_pkg::ST_RUN && k < kl
                    && kw[8*k +: 8] == i_ch) begin
                    o_step.kidx_nx[i] = kn;
                    o_step.st_nx[9+i] = (kn >= kl) ? ptok_pkg::ST_ACC : ptok_pkg::ST_RUN;
                end else begin
                    o_step.st_nx[9+i] = ptok_pkg::ST_REJ;
                end
            end
        end

        o_step.running  = 1'b0;
        o_step.any_acc  = 1'b0;
        o_step.acc_kind = ptok_pkg::K_ERROR;
        o_step.cut_kind = ptok_pkg::K_ERROR;
        for (int i = 0; i < ptok_pkg::NUM_M; i++) begin
            if (o_step.st_nx[i] == ptok_pkg::ST_RUN)
                o_step.running = 1'b1;
            if (o_step.st_nx[i] == ptok_pkg::ST_ACC) begin
                o_step.any_acc  = 1'b1;
                o_step.acc_kind = 4'(i);
            end
            if (((i == 1 || i == 8) && i_st[i] == ptok_pkg::ST_RUN)
                || (i >= 9 && i_st[i] == ptok_pkg::ST_ACC))
                o_step.cut_kind = 4'(i);
        end
    end

endmodule

### hw/rtl/parallel_automata_tokenizer.sv
// Parallel automata tokenizer top: text ring memory, scan sequencer, result staging.
// Depends on ptok_pkg and ptok_match. A beat with nothing to replay passes through
// accept, step and flush; each replayed char adds a ring read and a step; eof adds S_EOF.
// Results pass a pending and an output register: the last result of a beat is valid
// once flush moves it from pending to output, later while the output stalls or pending is blocked.
// Reset: synchronous, active low, clears all control state; ring needs no clearing.
`timescale 1ns / 1ps
module parallel_automata_tokenizer #(
    parameter int MAX_TOKEN_LEN = ptok_pkg::MAX_TOKEN_LEN,
    localparam int LEN_W  = $clog2(MAX_TOKEN_LEN + 2),
    localparam int OUT_BW = 4 + 32 + LEN_W + 1,
    localparam int OUT_W  = ((OUT_BW + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [7:0]       i_s_tdata,   // ch[7:0]
    input  logic             i_s_tlast,   // end_of_text
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata,   // token_kind, start_pos, token_len, too_long, pad
    output logic             o_m_tlast    // last_of_run
);

    localparam int FILL_W = $clog2(MAX_TOKEN_LEN + 1);
    // Ring holds the buffered token plus the replay queue, indexed by text offset.
    localparam int RING_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam int RING_D = 2 ** RING_W;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_EOF, S_FLUSH} t_state;

    t_state              r_state, n_state;
    logic [31:0]         r_scan, n_scan;      // offset of token start
    logic [31:0]         r_wpos, n_wpos;      // offset one past last written char
    logic [FILL_W-1:0]   r_fill, n_fill;
    ptok_pkg::t_mst_vec  r_st, n_st;
    ptok_pkg::t_kidx_vec r_kidx, n_kidx;
    logic                r_lastnl, n_lastnl;
    logic                r_eofm, n_eofm;      // end of text in progress
    logic [7:0]          r_cur, n_cur;        // char of the accepted beat
    logic                r_frommem, n_frommem;
    logic [7:0]          r_rdata;

    // pending result (not yet known whether last) and output register
    logic                r_pv, n_pv;
    ptok_pkg::t_kind     r_pk, n_pk;
    logic [31:0]         r_ps, n_ps;
    logic [LEN_W-1:0]    r_pl, n_pl;
    logic                r_pc, n_pc;
    logic                r_ov, n_ov;
    ptok_pkg::t_kind     r_ok, n_ok;
    logic [31:0]         r_os, n_os;
    logic [LEN_W-1:0]    r_ol, n_ol;
    logic                r_oc, n_oc;
    logic                r_olast, n_olast;

    logic [7:0]          ring [RING_D];
    logic                wr_en;
    logic [7:0]          wr_data;
    logic [RING_W-1:0]   rd_addr;

    logic [7:0]          cc;
    ptok_pkg::t_step     step;
    logic                s_acc, out_free;

    assign cc       = r_frommem ? r_rdata : r_cur;
    assign s_acc    = i_s_tvalid && o_s_tready;
    assign out_free = !r_ov || i_m_tready;
    assign rd_addr  = RING_W'(r_scan + 32'(r_fill));

    ptok_match u_match (
        .i_ch        (cc),
        .i_fill_zero (r_fill == '0),
        .i_st        (r_st),
        .i_kidx      (r_kidx),
        .o_step      (step)
    );

    always_comb begin
        logic [LEN_W-1:0]  take;
        logic [LEN_W-1:0]  n1;
        ptok_pkg::t_kind   kind;
        logic              has, cut, done, push;
        logic [31:0]       npos;
        n_state   = r_state;
        n_scan    = r_scan;
        n_wpos    = r_wpos;
        n_fill    = r_fill;
        n_st      = r_st;
        n_kidx    = r_kidx;
        n_lastnl  = r_lastnl;
        n_eofm    = r_eofm;
        n_cur     = r_cur;
        n_frommem = r_frommem;
        n_pv = r_pv; n_pk = r_pk; n_ps = r_ps; n_pl = r_pl; n_pc = r_pc;
        n_ov = r_ov; n_ok = r_ok; n_os = r_os; n_ol = r_ol; n_oc = r_oc;
        n_olast = r_olast;
        wr_en   = 1'b0;
        wr_data = i_s_tdata;
        take = '0; kind = ptok_pkg::K_ERROR; has = 1'b0; cut = 1'b0;
        done = 1'b0; push = 1'b0; npos = '0;
        n1   = LEN_W'(r_fill) + LEN_W'(1);

        if (r_ov && i_m_tready)
            n_ov = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_frommem = 1'b0;
                    if (i_s_tlast) begin
                        n_eofm = 1'b1;
                        if (!r_lastnl) begin
                            wr_en   = 1'b1;
                            wr_data = ptok_pkg::CH_NL;
                            n_cur   = ptok_pkg::CH_NL;
                            n_wpos  = r_wpos + 32'd1;
                            n_state = S_EXEC;
                        end else begin
                            n_state = S_EOF;
                        end
                    end else begin
                        wr_en    = 1'b1;
                        n_cur    = i_s_tdata;
                        n_wpos   = r_wpos + 32'd1;
                        n_lastnl = (i_s_tdata == ptok_pkg::CH_NL);
                        n_state  = S_EXEC;
                    end
                end
            end
            S_READ: begin
                n_frommem = 1'b1;
                n_state   = S_EXEC;
            end
            S_EXEC: begin
                if (step.running && r_fill < FILL_W'(MAX_TOKEN_LEN)) begin
                    n_st   = step.st_nx;
                    n_kidx = step.kidx_nx;
                    n_fill = r_fill + FILL_W'(1);
                    npos   = r_scan + 32'(n1);
                    done   = (npos == r_wpos);
                    n_state = done ? (r_eofm ? S_EOF : S_FLUSH) : S_READ;
                end else begin
                    if (step.running) begin
                        // token cut before this char
                        has  = 1'b1;
                        kind = step.cut_kind;
                        if (kind >= ptok_pkg::K_FIRST_KW) begin
                            take = LEN_W'(ptok_pkg::kw_len(3'(kind - ptok_pkg::K_FIRST_KW)));
                        end else begin
                            take = LEN_W'(r_fill);
                            cut  = 1'b1;
                        end
                    end else begin
                        has  = step.any_acc;
                        kind = step.acc_kind;
                        if (!has || kind == ptok_pkg::K_ERROR)
                            take = n1;
                        else if (kind == ptok_pkg::K_NUMBER || kind == ptok_pkg::K_IDENT)
                            take = LEN_W'(r_fill);
                        else if (kind >= ptok_pkg::K_FIRST_KW)
                            take = LEN_W'(ptok_pkg::kw_len(3'(kind - ptok_pkg::K_FIRST_KW)));
                        else
                            take = LEN_W'(1);
                    end
                    if (take > n1)
                        take = n1;
                    if (take == '0)
                        take = LEN_W'(1);
                    if (!(has && r_pv && !out_free)) begin
                        push   = has;
                        n_scan = r_scan + 32'(take);
                        n_fill = '0;
                        n_st   = '0;
                        n_kidx = '0;
                        npos   = r_scan + 32'(take);
                        done   = (npos == r_wpos);
                        n_state = done ? (r_eofm ? S_EOF : S_FLUSH) : S_READ;
                    end
                end
            end
            S_EOF: begin
                if (!(r_pv && !out_free)) begin
                    push     = 1'b1;
                    kind     = ptok_pkg::K_EOF;
                    take     = '0;
                    n_scan   = '0;
                    n_wpos   = '0;
                    n_fill   = '0;
                    n_st     = '0;
                    n_kidx   = '0;
                    n_lastnl = 1'b0;
                    n_eofm   = 1'b0;
                    n_state  = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!r_pv) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_ov = 1'b1; n_ok = r_pk; n_os = r_ps; n_ol = r_pl; n_oc = r_pc;
                    n_olast = 1'b1;
                    n_pv    = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (push) begin
            if (r_pv) begin
                n_ov = 1'b1; n_ok = r_pk; n_os = r_ps; n_ol = r_pl; n_oc = r_pc;
                n_olast = 1'b0;
            end
            n_pv = 1'b1;
            n_pk = kind;
            n_ps = r_scan;
            n_pl = take;
            n_pc = cut;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_scan   <= '0;
            r_wpos   <= '0;
            r_fill   <= '0;
            r_st     <= '0;
            r_kidx   <= '0;
            r_lastnl <= 1'b0;
            r_eofm   <= 1'b0;
            r_pv     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_scan   <= n_scan;
            r_wpos   <= n_wpos;
            r_fill   <= n_fill;
            r_st     <= n_st;
            r_kidx   <= n_kidx;
            r_lastnl <= n_lastnl;
            r_eofm   <= n_eofm;
            r_pv     <= n_pv;
            r_ov     <= n_ov;
        end
        r_cur     <= n_cur;
        r_frommem <= n_frommem;
        r_pk <= n_pk; r_ps <= n_ps; r_pl <= n_pl; r_pc <= n_pc;
        r_ok <= n_ok; r_os <= n_os; r_ol <= n_ol; r_oc <= n_oc;
        r_olast <= n_olast;
    end

    // text ring: write on accept, registered read for replay
    always_ff @(posedge i_clk) begin
        if (wr_en)
            ring[r_wpos[RING_W-1:0]] <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ)
            r_rdata <= ring[rd_addr];
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = OUT_W'({r_oc, r_ol, r_os, r_ok});

endmodule

### verif/tb_parallel_automata_tokenizer.sv
// Self-checking bench for parallel_automata_tokenizer: streams text bytes, predicts tokens
// in-bench and compares each output beat. Depends on ptok_pkg and the tokenizer RTL.
`timescale 1ns / 1ps
module tb_parallel_automata_tokenizer;

    localparam int OUT_W  = 48;
    localparam int LIMIT  = 1000000;
    localparam int M_NUM  = 1;
    localparam int M_ID   = 8;
    localparam int M_KW   = 9;

    typedef struct {
        bit [7:0] ch;
        bit       eot;
    } t_text_beat;

    typedef struct {
        ptok_pkg::t_kind kind;
        bit [31:0]       start;
        bit [5:0]        len;
        bit              cut;
        bit              last;
    } t_token;

    logic             i_clk = 0;
    logic             i_rst_n = 0;
    logic             s_tvalid = 0;
    logic             s_tready;
    logic [7:0]       s_tdata = 0;
    logic             s_tlast = 0;
    logic             m_tvalid;
    logic             m_tready = 0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;

    parallel_automata_tokenizer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tlast(s_tlast),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tlast(m_tlast)
    );

    always #2 i_clk = ~i_clk;

    t_text_beat pending_text[$];
    t_token     token_q[$];
    int         fails = 0;

    // tokenizer shadow state
    bit [7:0]        tok_buf[ptok_pkg::MAX_TOKEN_LEN];
    int              tok_fill;
    bit [31:0]       tok_start;
    ptok_pkg::t_mst  mst[ptok_pkg::NUM_M];
    int              kw_pos[ptok_pkg::NUM_KW];
    bit              saw_nl;
    bit [7:0]        rescan[$];
    string           kw_txt[ptok_pkg::NUM_KW] = '{"calc", "cd", "if", "for", "var", "while"};
    string           op_txt = "+-*/()";

    function automatic bit is_dig(bit [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_let(bit [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic void restart_token();
        foreach (mst[i]) mst[i] = ptok_pkg::ST_RUN;
        foreach (kw_pos[i]) kw_pos[i] = 0;
        tok_fill = 0;
    endfunction

    function automatic void clear_text();
        restart_token();
        tok_start = 0;
        saw_nl = 0;
    endfunction

    function automatic void advance_matchers(bit [7:0] c);
        int n;
        n = tok_fill;
        mst[0] = (n == 0 && (c == ptok_pkg::CH_SPACE || c == ptok_pkg::CH_NL))
                 ? ptok_pkg::ST_REJ : ptok_pkg::ST_ACC;
        if (mst[M_NUM] == ptok_pkg::ST_RUN)
            mst[M_NUM] = is_dig(c) ? ptok_pkg::ST_RUN
                                   : (n > 0 ? ptok_pkg::ST_ACC : ptok_pkg::ST_REJ);
        for (int i = 0; i < ptok_pkg::NUM_OP; i++)
            mst[2+i] = (mst[2+i] == ptok_pkg::ST_RUN && c == op_txt[i])
                       ? ptok_pkg::ST_ACC : ptok_pkg::ST_REJ;
        if (mst[M_ID] == ptok_pkg::ST_RUN) begin
            if (n == 0) mst[M_ID] = is_let(c) ? ptok_pkg::ST_RUN : ptok_pkg::ST_REJ;
            else mst[M_ID] = (is_let(c) || is_dig(c)) ? ptok_pkg::ST_RUN : ptok_pkg::ST_ACC;
        end
        for (int i = 0; i < ptok_pkg::NUM_KW; i++) begin
            if (mst[M_KW+i] == ptok_pkg::ST_ACC) continue;
            if (mst[M_KW+i] == ptok_pkg::ST_RUN && kw_pos[i] < kw_txt[i].len()
                    && kw_txt[i][kw_pos[i]] == c) begin
                kw_pos[i]++;
                if (kw_pos[i] >= kw_txt[i].len()) mst[M_KW+i] = ptok_pkg::ST_ACC;
            end else begin
                mst[M_KW+i] = ptok_pkg::ST_REJ;
            end
        end
    endfunction

    function automatic void add_token(int kind, int len, bit cut);
        t_token t;
        t.kind = ptok_pkg::t_kind'(kind); t.start = tok_start; t.len = 6'(len);
        t.cut = cut; t.last = 0;
        token_q.insert(token_q.size(), t);
    endfunction

    // Scans everything in rescan; a finished token puts its tail back for rescanning.
    function automatic void scan_text();
        bit [7:0]       c;
        int             n, take, kind;
        bit             running, cut, acc;
        ptok_pkg::t_mst held_st[ptok_pkg::NUM_M];
        int             held_kw[ptok_pkg::NUM_KW];
        while (rescan.size() > 0) begin
            c = rescan.pop_front();
            n = tok_fill;
            take = 1; kind = -1; running = 0; cut = 0;
            held_st = mst;
            held_kw = kw_pos;
            advance_matchers(c);
            foreach (mst[i]) if (mst[i] == ptok_pkg::ST_RUN) running = 1;
            if (running && n < ptok_pkg::MAX_TOKEN_LEN) begin
                tok_buf[n] = c;
                tok_fill = n + 1;
                continue;
            end
            if (running) begin
                // buffer full: decide on the states held before this byte
                mst = held_st;
                kw_pos = held_kw;
                for (int i = 0; i < ptok_pkg::NUM_M; i++) begin
                    acc = (i == M_NUM || i == M_ID) ? mst[i] == ptok_pkg::ST_RUN
                        : (i >= M_KW && mst[i] == ptok_pkg::ST_ACC);
                    if (acc) kind = i;
                end
                if (kind >= M_KW) take = kw_txt[kind-M_KW].len();
                else begin
                    if (kind < 0) kind = 0;
                    take = n;
                    cut = 1;
                end
            end else begin
                for (int i = 0; i < ptok_pkg::NUM_M; i++)
                    if (mst[i] == ptok_pkg::ST_ACC) kind = i;
                if (kind <= 0) take = n + 1;
                else if (kind == M_NUM || kind == M_ID) take = n;
                else if (kind >= M_KW) take = kw_txt[kind-M_KW].len();
                else take = 1;
            end
            if (take > n + 1) take = n + 1;
            if (take == 0) take = 1;
            if (kind >= 0) add_token(kind, take, cut);
            tok_start += 32'(take);
            for (int i = n; i >= take; i--) rescan.push_front(i < n ? tok_buf[i] : c);
            restart_token();
        end
    endfunction

    function automatic void predict_tokens(bit [7:0] ch, bit eot);
        int prior_cnt;
        prior_cnt = token_q.size();
        if (eot) begin
            if (!saw_nl) begin
                rescan.insert(rescan.size(), ptok_pkg::CH_NL);
                scan_text();
            end
            add_token(ptok_pkg::K_EOF, 0, 0);
            clear_text();
        end else begin
            rescan.insert(rescan.size(), ch);
            scan_text();
            saw_nl = (ch == ptok_pkg::CH_NL);
        end
        if (token_q.size() > prior_cnt) token_q[$].last = 1;
    endfunction

    // ---- driver ----
    int send_gap = 0;
    bit send_burst = 0;
    always @(posedge i_clk) begin
        t_text_beat b;
        if (!i_rst_n) begin
            s_tvalid <= 0;
        end else begin
            if (s_tvalid && s_tready) predict_tokens(s_tdata, s_tlast);
            if (!(s_tvalid && !s_tready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 0;
                end else if (pending_text.size() > 0) begin
                    b = pending_text.pop_front();
                    s_tdata <= b.ch;
                    s_tlast <= b.eot;
                    s_tvalid <= 1;
                    if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
                    send_gap = send_burst ? 0 : $urandom_range(0, 12);
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // ---- monitor ----
    int recv_stall = 0;
    bit recv_burst = 0;
    always @(posedge i_clk) begin
        t_token e;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (token_q.size() == 0) begin
                $error("token beat with nothing expected: %h", m_tdata);
                fails++;
            end else begin
                e = token_q.pop_front();
                if (m_tdata[3:0] != e.kind) begin
                    $error("token_kind exp %0d got %0d", e.kind, m_tdata[3:0]); fails++;
                end
                if (m_tdata[35:4] != e.start) begin
                    $error("start_pos exp %0d got %0d", e.start, m_tdata[35:4]); fails++;
                end
                if (m_tdata[41:36] != e.len) begin
                    $error("token_len exp %0d got %0d", e.len, m_tdata[41:36]); fails++;
                end
                if (m_tdata[42] != e.cut) begin
                    $error("too_long exp %0d got %0d", e.cut, m_tdata[42]); fails++;
                end
                if (m_tlast != e.last) begin
                    $error("last_of_run exp %0d got %0d", e.last, m_tlast); fails++;
                end
            end
        end
        if (recv_stall > 0) begin
            recv_stall--;
            m_tready <= 0;
        end else begin
            m_tready <= 1;
            if (m_tvalid && m_tready) begin
                if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
                recv_stall = recv_burst ? 0 : $urandom_range(0, 12);
            end
        end
    end

    int cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic queue_char(bit [7:0] c);
        t_text_beat b;
        b.ch = c; b.eot = 0;
        pending_text.insert(pending_text.size(), b);
    endtask

    task automatic queue_eot();
        t_text_beat b;
        b.ch = 8'($urandom_range(0, 255)); b.eot = 1;
        pending_text.insert(pending_text.size(), b);
    endtask

    task automatic queue_word(string s);
        for (int i = 0; i < s.len(); i++) queue_char(s[i]);
    endtask

    task automatic wait_drained();
        do begin
            @(posedge i_clk); #1;
        end while (pending_text.size() > 0 || s_tvalid || token_q.size() > 0);
        repeat (20) @(posedge i_clk);
    endtask

    string vocab[] = '{"calc", "cd", "if", "for", "var", "while", "whilex", "ca", "cdif",
                       "fo", "x1", "Abc9", "0", "42", "7x", "+", "-", "*", "/", "(", ")",
                       "varz", "i"};

    initial begin
        int n;
        clear_text();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        // keywords, keyword prefix of identifier, operators, high bytes, tab, eof without
        // newline, then an empty text
        queue_word("calc cdif+for-var*while/(9)");
        queue_char(8'h80);
        queue_char(8'hFF);
        queue_char(8'h09);
        queue_eot();
        queue_eot();
        wait_drained();   // sender holds until every token has come back

        while (pending_text.size() < 220) begin
            n = $urandom_range(0, 99);
            if (n < 60) queue_word(vocab[$urandom_range(0, vocab.size()-1)]);
            else if (n < 70) queue_char(ptok_pkg::CH_SPACE);
            else if (n < 75) queue_char(ptok_pkg::CH_NL);
            else if (n < 85) queue_char(8'($urandom_range(0, 255)));
            else if (n < 90) queue_eot();
            else if (n < 93) begin
                // long identifier or number, up to and past the token length limit
                repeat ($urandom_range(30, 40))
                    queue_char(n == 90 ? 8'("9") : 8'($urandom_range("a", "z")));
            end else queue_char(ptok_pkg::CH_SPACE);
        end
        queue_eot();
        wait_drained();

        if (fails == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
